// ===== rtl/core/hns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hns_pkg
// Shared constants, result type and helpers of the heightfield normal stencil.
// ----------------------------------------------------------------------------
package hns_pkg;

    localparam int MAX_RES   = 256;
    localparam int DEPTH     = MAX_RES + 1;
    localparam int H_W       = 16;
    localparam int N_W       = 17;
    localparam int IDX_W     = 9;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;
    localparam int DATA_W    = 56;
    localparam int PAYLOAD_W = 2 * N_W + 2 * IDX_W;

    localparam logic [IDX_W-1:0] RES_RESET = IDX_W'(64);
    localparam logic [IDX_W-1:0] RES_MIN   = IDX_W'(2);
    localparam logic [IDX_W-1:0] RES_MAX   = IDX_W'(MAX_RES);

    typedef struct packed {
        logic                    last;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [N_W-1:0]   ny;
        logic signed [N_W-1:0]   nx;
    } t_result;

    function automatic logic signed [N_W-1:0] diff(
        input logic [H_W-1:0] a,
        input logic [H_W-1:0] b
    );
        logic signed [N_W-1:0] ea;
        logic signed [N_W-1:0] eb;
        ea = $signed({a[H_W-1], a});
        eb = $signed({b[H_W-1], b});
        return ea - eb;
    endfunction

    function automatic logic [IDX_W-1:0] clamp_res(input logic [IDX_W-1:0] v);
        logic [IDX_W-1:0] r;
        if (v < RES_MIN) begin
            r = RES_MIN;
        end else if (v > RES_MAX) begin
            r = RES_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/heightfield_normal_stencil.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_normal_stencil
// Central-difference normals of a raster-ordered square heightfield, using
// two row line buffers; results trail the input by one row.
// ----------------------------------------------------------------------------
//  channel   direction  signals                         content
//  s         in         i_s_tvalid/o_s_tready/i_s_tdata height sample, Q12.4
//  m         out        o_m_tvalid/i_m_tready/o_m_tdata normal x/y, col, row
//                       o_m_tlast                       last result of a sample
//  cfg       in         i_cfg_we/i_cfg_wdata            grid_res
//
//  While the sink is ready, one sample per cycle on rows that give one result
//  (and on the first row, which gives none); the bottom row gives up to three
//  results per sample and runs at one result per cycle, set by the single
//  output port. Results are queued in a four-entry buffer; a sample is taken
//  while it holds at most one result. A grid_res write restarts the raster at
//  0,0. Reset is synchronous; line buffers are not cleared.
// ----------------------------------------------------------------------------
module heightfield_normal_stencil (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] height
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [16:0] normal_x, [33:17] normal_y,
                                     // [42:34] col, [51:43] row, [55:52] zero
    output logic        o_m_tlast
);

    logic [hns_pkg::H_W-1:0]    r_prev_mem [hns_pkg::DEPTH];
    logic [hns_pkg::H_W-1:0]    r_older_mem [hns_pkg::DEPTH];

    logic [hns_pkg::IDX_W-1:0]  r_res;
    logic [hns_pkg::IDX_W-1:0]  r_col;
    logic [hns_pkg::IDX_W-1:0]  r_row;

    logic [hns_pkg::H_W-1:0]    r_up1;
    logic [hns_pkg::H_W-1:0]    r_up0;
    logic [hns_pkg::H_W-1:0]    r_prev_sample;
    logic [hns_pkg::H_W-1:0]    r_old;
    logic [hns_pkg::H_W-1:0]    r_h1;
    logic [hns_pkg::H_W-1:0]    r_h2;

    hns_pkg::t_result           r_q [hns_pkg::QDEPTH];
    logic [hns_pkg::QPTR_W-1:0] r_wr;
    logic [hns_pkg::QPTR_W-1:0] r_rd;
    logic [hns_pkg::QCNT_W-1:0] r_cnt;
    logic [hns_pkg::QCNT_W-1:0] n_cnt;

    logic                       w_in_acc;
    logic                       w_out_acc;
    logic [hns_pkg::IDX_W-1:0]  w_a1;
    logic [hns_pkg::IDX_W-1:0]  w_a2;
    logic                       w_col_last;
    logic                       w_row_last;
    logic                       w_v0;
    logic                       w_v1;
    logic                       w_v2;
    logic [hns_pkg::QCNT_W-1:0] w_push;
    hns_pkg::t_result           w_e0;
    hns_pkg::t_result           w_e1;
    hns_pkg::t_result           w_e2;
    hns_pkg::t_result           w_head;

    assign o_s_tready = (r_cnt <= hns_pkg::QCNT_W'(1));
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_cnt != '0);
    assign w_out_acc  = o_m_tvalid && i_m_tready;

    assign w_head    = r_q[r_rd];
    assign o_m_tdata = {{(hns_pkg::DATA_W - hns_pkg::PAYLOAD_W){1'b0}},
                        w_head.row, w_head.col, w_head.ny, w_head.nx};
    assign o_m_tlast = w_head.last;

    assign w_col_last = (r_col == r_res);
    assign w_row_last = (r_row == r_res);

    always_comb begin
        w_a1 = w_col_last ? '0 : r_col + hns_pkg::IDX_W'(1);
        if (w_col_last) begin
            w_a2 = hns_pkg::IDX_W'(1);
        end else if (r_col + hns_pkg::IDX_W'(1) == r_res) begin
            w_a2 = '0;
        end else begin
            w_a2 = r_col + hns_pkg::IDX_W'(2);
        end
    end

    always_comb begin
        w_v0 = (r_row != '0);
        w_v1 = w_row_last && (r_col != '0);
        w_v2 = w_row_last && w_col_last;

        w_e0.nx   = (r_col == '0 || w_col_last) ? '0
                  : hns_pkg::diff(r_prev_sample, r_up1);
        w_e0.ny   = (r_row == hns_pkg::IDX_W'(1)) ? '0
                  : hns_pkg::diff(r_old, i_s_tdata);
        w_e0.col  = r_col;
        w_e0.row  = r_row - hns_pkg::IDX_W'(1);
        w_e0.last = !w_v1;

        w_e1.nx   = (r_col == hns_pkg::IDX_W'(1)) ? '0
                  : hns_pkg::diff(r_h2, i_s_tdata);
        w_e1.ny   = '0;
        w_e1.col  = r_col - hns_pkg::IDX_W'(1);
        w_e1.row  = r_res;
        w_e1.last = !w_v2;

        w_e2.nx   = '0;
        w_e2.ny   = '0;
        w_e2.col  = r_res;
        w_e2.row  = r_res;
        w_e2.last = 1'b1;

        w_push = w_in_acc ? (hns_pkg::QCNT_W'(w_v0) + hns_pkg::QCNT_W'(w_v1)
                             + hns_pkg::QCNT_W'(w_v2)) : '0;
        n_cnt  = r_cnt + w_push - hns_pkg::QCNT_W'(w_out_acc);
    end

    // line buffers and prefetch window
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_prev_mem[r_col] <= i_s_tdata;
            r_up1             <= r_prev_mem[w_a2];
            r_up0             <= r_up1;
            r_prev_sample     <= r_up0;
            r_old             <= r_older_mem[w_a1];
            r_h1              <= i_s_tdata;
            r_h2              <= r_h1;
            if (w_v0) begin
                r_older_mem[r_col] <= r_up0;
            end
        end
    end

    // result queue payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (w_v0) begin
                r_q[r_wr] <= w_e0;
            end
            if (w_v1) begin
                r_q[r_wr + hns_pkg::QPTR_W'(1)] <= w_e1;
            end
            if (w_v2) begin
                r_q[r_wr + hns_pkg::QPTR_W'(2)] <= w_e2;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= hns_pkg::RES_RESET;
            r_col <= '0;
            r_row <= '0;
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_wr  <= r_wr + hns_pkg::QPTR_W'(w_push);
            if (w_out_acc) begin
                r_rd <= r_rd + hns_pkg::QPTR_W'(1);
            end
            if (i_cfg_we) begin
                r_res <= hns_pkg::clamp_res(i_cfg_wdata);
                r_col <= '0;
                r_row <= '0;
            end else if (w_in_acc) begin
                if (w_col_last) begin
                    r_col <= '0;
                    r_row <= w_row_last ? '0 : r_row + hns_pkg::IDX_W'(1);
                end else begin
                    r_col <= r_col + hns_pkg::IDX_W'(1);
                end
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= hns_pkg::QCNT_W'(hns_pkg::QDEPTH))
        else $error("result queue overflow");

    a_raster_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_res && r_row <= r_res && r_res >= hns_pkg::RES_MIN
        && r_res <= hns_pkg::RES_MAX)
        else $error("raster position outside grid");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_row != '0 && !i_cfg_we) |=> o_m_tvalid)
        else $error("transaction gave no result");

endmodule

// ===== sim/tb_heightfield_normal_stencil.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heightfield_normal_stencil
// Streams heightfield grids of several sizes into the stencil, including the
// clamped register values and the opening rows of the widest grid. A
// behavioral line-buffer model predicts every normal, and each output
// transaction is checked against the oldest prediction. Source gaps, sink
// stalls, one long sink hold and one mid-grid source pause are applied in
// separate phases.
// ----------------------------------------------------------------------------
module tb_heightfield_normal_stencil;

    localparam int RUN_LIMIT = 200_000;
    localparam int LONG_HOLD = 400;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [8:0]  i_cfg_wdata = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [55:0] o_m_tdata;
    logic        o_m_tlast;

    heightfield_normal_stencil dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // stencil model state
    logic [hns_pkg::H_W-1:0]   line_prev [0:hns_pkg::DEPTH-1];
    logic [hns_pkg::H_W-1:0]   line_older [0:hns_pkg::DEPTH-1];
    logic [hns_pkg::H_W-1:0]   upper_left = '0;
    logic [hns_pkg::IDX_W-1:0] res_reg    = hns_pkg::RES_RESET;
    int unsigned               pos_col    = 0;
    int unsigned               pos_row    = 0;

    logic [hns_pkg::H_W-1:0] height_q [$];
    hns_pkg::t_result        normal_q [$];
    int unsigned    heights_queued = 0;
    int unsigned    heights_taken  = 0;
    int unsigned    mismatch_cnt   = 0;
    int unsigned    cycle_cnt      = 0;
    int unsigned    tx_idle_pct    = 0;
    int unsigned    rx_stall_pct   = 0;
    logic           rx_hold        = 1'b0;
    logic           hold_go        = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int height_diff(input logic [hns_pkg::H_W-1:0] a,
                                       input logic [hns_pkg::H_W-1:0] b);
        return int'($signed(a)) - int'($signed(b));
    endfunction

    function automatic hns_pkg::t_result make_normal(input int x, input int y,
                                                     input int unsigned c,
                                                     input int unsigned r);
        hns_pkg::t_result n;
        n.last = 1'b0;
        n.row  = hns_pkg::IDX_W'(r);
        n.col  = hns_pkg::IDX_W'(c);
        n.ny   = hns_pkg::N_W'(y);
        n.nx   = hns_pkg::N_W'(x);
        return n;
    endfunction

    task automatic predict_normals(input logic [hns_pkg::H_W-1:0] h);
        int unsigned      side;
        int unsigned      c;
        int unsigned      r;
        int               dx;
        int               dy;
        hns_pkg::t_result batch [$];
        side = (res_reg < hns_pkg::RES_MIN) ? int'(hns_pkg::RES_MIN) :
               (res_reg > hns_pkg::RES_MAX) ? hns_pkg::MAX_RES : int'(res_reg);
        c = pos_col;
        r = pos_row;
        if (r >= 1) begin
            dx = 0;
            dy = 0;
            if (r - 1 != 0) begin
                dy = height_diff(line_older[c], h);
            end
            if (c != 0 && c != side) begin
                dx = height_diff(upper_left, line_prev[c + 1]);
            end
            batch.push_back(make_normal(dx, dy, c, r - 1));
            if (r == side) begin
                if (c >= 1) begin
                    dx = (c - 1 != 0) ? height_diff(line_prev[c - 2], h) : 0;
                    batch.push_back(make_normal(dx, 0, c - 1, side));
                end
                if (c == side) begin
                    batch.push_back(make_normal(0, 0, side, side));
                end
            end
            line_older[c] = line_prev[c];
            upper_left    = line_prev[c];
        end
        line_prev[c] = h;
        c++;
        if (c > side) begin
            c = 0;
            r++;
            if (r > side) begin
                r = 0;
            end
        end
        pos_col = c;
        pos_row = r;
        if (batch.size() != 0) begin
            batch[batch.size() - 1].last = 1'b1;
        end
        foreach (batch[i]) begin
            normal_q.push_back(batch[i]);
        end
    endtask

    always @(posedge i_clk) begin : tx_side
        logic busy;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            busy = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                predict_normals(i_s_tdata);
                heights_taken++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (height_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    i_s_tdata  <= height_q.pop_front();
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : rx_side
        hns_pkg::t_result got;
        hns_pkg::t_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = hns_pkg::t_result'({o_m_tlast, o_m_tdata[51:0]});
                if (normal_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("unexpected normal: nx=%0d ny=%0d col=%0d row=%0d last=%0b",
                                 got.nx, got.ny, got.col, got.row, got.last);
                    end
                end else begin
                    want = normal_q.pop_front();
                    if (got.nx !== want.nx || got.ny !== want.ny || got.col !== want.col ||
                        got.row !== want.row || got.last !== want.last ||
                        o_m_tdata[55:52] !== 4'b0) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("normal mismatch: want nx=%0d ny=%0d col=%0d row=%0d last=%0b",
                                     want.nx, want.ny, want.col, want.row, want.last);
                            $display("  got nx=%0d ny=%0d col=%0d row=%0d last=%0b pad=%h",
                                     got.nx, got.ny, got.col, got.row, got.last,
                                     o_m_tdata[55:52]);
                        end
                    end
                end
            end
            i_m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // hold the sink once requested, then release it
    initial begin : sink_hold
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    function automatic logic [hns_pkg::H_W-1:0] rand_height();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_height(input logic [hns_pkg::H_W-1:0] h);
        height_q.push_back(h);
        heights_queued++;
    endtask

    task automatic push_random(input int count);
        repeat (count) push_height(rand_height());
    endtask

    task automatic set_idle(input int unsigned tx_pct, input int unsigned rx_pct);
        @(posedge i_clk);
        tx_idle_pct  <= tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    // hold until every sample is taken and every normal has arrived
    task automatic wait_drained(input int gap);
        while (heights_taken != heights_queued || normal_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic write_grid_res(input logic [hns_pkg::IDX_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        res_reg = v;
        pos_col = 0;
        pos_row = 0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : sequencer
        logic [hns_pkg::H_W-1:0] grid_a [9];
        logic [hns_pkg::H_W-1:0] grid_b [9];
        grid_a = '{16'h7fff, 16'h0000, 16'h8000,
                   16'h8000, 16'h0001, 16'h7fff,
                   16'hffff, 16'h8000, 16'h0000};
        grid_b = '{16'h8000, 16'hffff, 16'h7fff,
                   16'h7fff, 16'h8000, 16'h8000,
                   16'h0000, 16'h7fff, 16'h8000};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest grid through a below-range register value, full-scale steps
        write_grid_res(9'd0);
        foreach (grid_a[i]) push_height(grid_a[i]);
        wait_drained(8);
        // abandon a grid part way, then restart it by a register write
        push_height(16'h1234);
        push_height(16'hedcb);
        push_height(16'h7fff);
        push_height(16'h8000);
        wait_drained(8);
        write_grid_res(9'd1);
        foreach (grid_b[i]) push_height(grid_b[i]);
        wait_drained(8);

        write_grid_res(9'd2);
        set_idle(0, 0);
        push_random(2 * 9);
        wait_drained(8);

        write_grid_res(9'd3);
        set_idle(72, 0);
        push_random(16);
        wait_drained(8);

        write_grid_res(9'd5);
        set_idle(0, 72);
        push_random(36);
        wait_drained(8);

        write_grid_res(9'd4);
        set_idle(7, 7);
        push_random(25);
        wait_drained(8);

        // pause the source mid-grid until the output side is empty
        write_grid_res(9'd6);
        set_idle(0, 0);
        push_random(20);
        wait_drained(0);

        // hold the sink while the source keeps offering
        push_random(29);
        hold_go <= 1'b1;
        wait_drained(8);

        // above-range values clamp to the widest grid
        write_grid_res(9'h1ff);
        set_idle(7, 7);
        push_random(257 + 9);
        wait_drained(20);

        if (mismatch_cnt == 0 && normal_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== heightfield_normal_stencil.f =====
rtl/core/hns_pkg.sv
rtl/core/heightfield_normal_stencil.sv
sim/tb_heightfield_normal_stencil.sv
